/* src/mefc_pkg.sv */
// ----------------------------------------------------------------------------
// mefc_pkg
// Shared types and constants of the mirrored-edge fir convolver.
// ----------------------------------------------------------------------------
package mefc_pkg;

    localparam int SW               = 16;
    localparam int FRAC             = SW - 1;
    localparam int RADIUS_CAP_DEF   = 31;
    localparam int MAX_RECORD_DEF   = 65536;
    localparam int S_TDATA_W        = 24;
    localparam int M_TDATA_W        = 32;
    localparam int CFG_W            = 5;
    localparam int TAP_IDX_W        = 6;
    localparam int OUT_IDX_W        = 16;

    localparam logic CMD_TAP        = 1'b0;
    localparam logic CMD_SAMPLE     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEEK,
        ST_MAC,
        ST_DRAIN,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic up;
        logic dn;
    } rot_ctl_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic tap_we;
    } mac_ctl_t;

endpackage

/* src/mefc_cell.sv */
// ----------------------------------------------------------------------------
// mefc_cell
// One window cell: a shift stage for incoming samples and a rotating stage
// that walks the window past the multiplier.
// ----------------------------------------------------------------------------
module mefc_cell (
    input  logic                            aclk,
    input  logic                            push,
    input  logic signed [mefc_pkg::SW-1:0]  win_in,
    output logic signed [mefc_pkg::SW-1:0]  win_out,
    input  mefc_pkg::rot_ctl_t              rot_ctl,
    input  logic signed [mefc_pkg::SW-1:0]  rot_from_next,
    input  logic signed [mefc_pkg::SW-1:0]  rot_from_prev,
    output logic signed [mefc_pkg::SW-1:0]  rot_out
);
    import mefc_pkg::*;

    logic signed [SW-1:0] win_reg;
    logic signed [SW-1:0] rot_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            win_reg <= win_in;
        end
        if (rot_ctl.load) begin
            rot_reg <= win_reg;
        end else if (rot_ctl.up) begin
            rot_reg <= rot_from_next;
        end else if (rot_ctl.dn) begin
            rot_reg <= rot_from_prev;
        end
    end

    assign win_out = win_reg;
    assign rot_out = rot_reg;

endmodule

/* src/mefc_mac.sv */
// ----------------------------------------------------------------------------
// mefc_mac
// Tap store, multiply-accumulate pipeline and round/saturate of the sum.
// ----------------------------------------------------------------------------
module mefc_mac #(
    parameter int DEPTH = 2 * mefc_pkg::RADIUS_CAP_DEF + 1,
    parameter int AW    = $clog2(2 * mefc_pkg::RADIUS_CAP_DEF + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mefc_pkg::mac_ctl_t              ctl,
    input  logic [AW-1:0]                   tap_waddr,
    input  logic signed [mefc_pkg::SW-1:0]  tap_wdata,
    input  logic [AW-1:0]                   tap_raddr,
    input  logic signed [mefc_pkg::SW-1:0]  sample,
    output logic signed [mefc_pkg::SW-1:0]  filtered
);
    import mefc_pkg::*;

    localparam int ACC_W = 2 * SW + $clog2(DEPTH) + 1;

    logic signed [SW-1:0]    tap_mem [DEPTH];
    logic signed [SW-1:0]    tap_q_reg;
    logic signed [SW-1:0]    smp_reg;
    logic                    vld1_reg;
    logic signed [2*SW-1:0]  prod_reg;
    logic                    vld2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] q;

    always_ff @(posedge aclk) begin
        if (ctl.tap_we) begin
            tap_mem[tap_waddr] <= tap_wdata;
        end
        tap_q_reg <= tap_mem[tap_raddr];
    end

    always_ff @(posedge aclk) begin
        smp_reg  <= sample;
        prod_reg <= tap_q_reg * smp_reg;
        if (ctl.clear) begin
            acc_reg <= '0;
        end else if (vld2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            vld1_reg <= ctl.issue;
            vld2_reg <= vld1_reg;
        end
    end

    // round half up, then saturate
    always_comb begin
        rnd = acc_reg + (ACC_W'(1) <<< (FRAC - 1));
        q   = rnd >>> FRAC;
        if (q > ACC_W'((1 << (SW - 1)) - 1)) begin
            filtered = {1'b0, {(SW-1){1'b1}}};
        end else if (q < -(ACC_W'(1) <<< (SW - 1))) begin
            filtered = {1'b1, {(SW-1){1'b0}}};
        end else begin
            filtered = q[SW-1:0];
        end
    end

endmodule

/* src/mirrored_edge_fir_convolver.sv */
// ----------------------------------------------------------------------------
// mirrored_edge_fir_convolver
// Odd-length fir over a finite record with mirrored edges, one output at a time.
// Per output: load, a seek of the rotating window, the mac over 2*radius+1 taps,
// drain and finish, then the out state holds the result until m_tready.
// Items are taken one at a time: s_tready is high only in idle.
// The final sample emits all pending outputs in sequence; short ones skip seek to drain.
// Reset (aresetn low, synchronous) clears radius, counters and handshake state.
// ----------------------------------------------------------------------------
module mirrored_edge_fir_convolver #(
    parameter int RADIUS_CAP = mefc_pkg::RADIUS_CAP_DEF,
    parameter int MAX_RECORD = mefc_pkg::MAX_RECORD_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mefc_pkg::CFG_W-1:0]        cfg_wr_data,   // radius
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mefc_pkg::S_TDATA_W-1:0]    s_tdata,       // tap_index, value, pad
    input  logic                              s_tuser,       // command
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mefc_pkg::M_TDATA_W-1:0]    m_tdata,       // filtered, out_index
    output logic                              m_tuser,       // short_record
    output logic                              m_tlast
);
    import mefc_pkg::*;

    localparam int DEPTH = 2 * RADIUS_CAP + 1;
    localparam int DW    = $clog2(DEPTH);
    localparam int RW    = $clog2(RADIUS_CAP + 1);
    localparam int IW    = $clog2(MAX_RECORD);
    localparam int PW    = ((IW > DW) ? IW : DW) + 2;

    state_t state_reg, state_next;

    logic [RW-1:0]        radius_reg;
    logic [IW-1:0]        seen_reg;
    logic [IW-1:0]        nout_reg;
    logic [IW-1:0]        cur_i_reg;
    logic [IW-1:0]        mx_reg;
    logic                 flush_reg;
    logic                 shrt_reg;
    logic [DW-1:0]        j_reg;
    logic [DW-1:0]        cur_d_reg;
    logic                 drain_reg;
    logic                 m_tvalid_reg;
    logic signed [SW-1:0] filt_reg;
    logic [IW-1:0]        oidx_reg;
    logic                 eor_reg;
    logic                 osh_reg;

    logic [TAP_IDX_W-1:0] s_tap_index;
    logic signed [SW-1:0] s_value;
    logic                 acc_in;
    logic                 is_sample;
    logic                 is_last;
    logic                 starts;
    logic                 j_last;
    logic                 more;

    logic [DW:0]          jq;
    logic signed [PW-1:0] p0, p1, p2, p3, mxs, dd;
    logic [DW-1:0]        tgt;

    rot_ctl_t             rot_ctl;
    mac_ctl_t             mac_ctl;
    logic signed [SW-1:0] win_q [DEPTH];
    logic signed [SW-1:0] rot_q [DEPTH];
    logic signed [SW-1:0] mac_filtered;

    assign s_tap_index = s_tdata[TAP_IDX_W-1:0];
    assign s_value     = s_tdata[TAP_IDX_W +: SW];
    assign s_tready    = (state_reg == ST_IDLE);
    assign acc_in      = s_tvalid && s_tready;
    assign is_sample   = (s_tuser == CMD_SAMPLE);
    assign is_last     = s_tlast || (32'(seen_reg) == MAX_RECORD - 1);
    assign starts      = is_last || (32'(seen_reg) >= 32'(radius_reg));
    assign j_last      = (32'(j_reg) == 2 * 32'(radius_reg));
    assign more        = flush_reg && (cur_i_reg != mx_reg);

    // mirrored sample offset for the tap in work
    always_comb begin
        jq  = (state_reg == ST_MAC) ? ((DW+1)'(j_reg) + 1'b1) : (DW+1)'(j_reg);
        mxs = signed'(PW'(mx_reg));
        p0  = signed'(PW'(cur_i_reg)) + signed'(PW'(jq)) - signed'(PW'(radius_reg));
        p1  = (p0 < 0) ? -p0 : p0;
        p2  = (p1 > mxs) ? (mxs + mxs - p1) : p1;
        p3  = (p2 < 0) ? '0 : p2;
        dd  = mxs - p3;
        tgt = dd[DW-1:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc_in && is_sample && starts) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = shrt_reg ? ST_FIN : ST_SEEK;
            end
            ST_SEEK: begin
                if (tgt == cur_d_reg) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (j_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = more ? ST_LOAD : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        rot_ctl        = '0;
        mac_ctl        = '0;
        mac_ctl.tap_we = acc_in && !is_sample && (32'(s_tap_index) < DEPTH);
        case (state_reg)
            ST_LOAD: begin
                rot_ctl.load  = 1'b1;
                mac_ctl.clear = 1'b1;
            end
            ST_SEEK: begin
                rot_ctl.up = (tgt > cur_d_reg);
                rot_ctl.dn = (tgt < cur_d_reg);
            end
            ST_MAC: begin
                mac_ctl.issue = 1'b1;
                rot_ctl.up    = !j_last && (tgt > cur_d_reg);
                rot_ctl.dn    = !j_last && (tgt < cur_d_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            radius_reg   <= '0;
            seen_reg     <= '0;
            nout_reg     <= '0;
            flush_reg    <= 1'b0;
            shrt_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en && (seen_reg == '0)) begin
                if (32'(cfg_wr_data) > RADIUS_CAP) begin
                    radius_reg <= RW'(RADIUS_CAP);
                end else begin
                    radius_reg <= RW'(cfg_wr_data);
                end
            end
            if (acc_in && is_sample) begin
                cur_i_reg <= nout_reg;
                mx_reg    <= seen_reg;
                flush_reg <= is_last;
                shrt_reg  <= is_last && (32'(seen_reg) < 32'(radius_reg));
                if (is_last) begin
                    seen_reg <= '0;
                    nout_reg <= '0;
                end else begin
                    seen_reg <= seen_reg + 1'b1;
                    if (starts) begin
                        nout_reg <= nout_reg + 1'b1;
                    end
                end
            end
            case (state_reg)
                ST_LOAD: begin
                    cur_d_reg <= '0;
                    j_reg     <= '0;
                    drain_reg <= 1'b0;
                end
                ST_SEEK: begin
                    if (rot_ctl.up) begin
                        cur_d_reg <= cur_d_reg + 1'b1;
                    end else if (rot_ctl.dn) begin
                        cur_d_reg <= cur_d_reg - 1'b1;
                    end
                end
                ST_MAC: begin
                    j_reg <= j_reg + 1'b1;
                    if (rot_ctl.up) begin
                        cur_d_reg <= cur_d_reg + 1'b1;
                    end else if (rot_ctl.dn) begin
                        cur_d_reg <= cur_d_reg - 1'b1;
                    end
                end
                ST_DRAIN: begin
                    drain_reg <= 1'b1;
                end
                ST_FIN: begin
                    m_tvalid_reg <= 1'b1;
                    filt_reg     <= shrt_reg ? '0 : mac_filtered;
                    oidx_reg     <= cur_i_reg;
                    eor_reg      <= flush_reg && (cur_i_reg == mx_reg);
                    osh_reg      <= shrt_reg;
                end
                ST_OUT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (more) begin
                            cur_i_reg <= cur_i_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // sample cells: cell 0 holds the newest sample, rotation walks the window
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        mefc_cell u_cell (
            .aclk          (aclk),
            .push          (acc_in && is_sample),
            .win_in        ((k == 0) ? s_value : win_q[(k == 0) ? 0 : k - 1]),
            .win_out       (win_q[k]),
            .rot_ctl       (rot_ctl),
            .rot_from_next (rot_q[(k + 1) % DEPTH]),
            .rot_from_prev (rot_q[(k + DEPTH - 1) % DEPTH]),
            .rot_out       (rot_q[k])
        );
    end

    mefc_mac #(
        .DEPTH (DEPTH),
        .AW    (DW)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (mac_ctl),
        .tap_waddr (DW'(s_tap_index)),
        .tap_wdata (s_value),
        .tap_raddr (j_reg),
        .sample    (rot_q[0]),
        .filtered  (mac_filtered)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {OUT_IDX_W'(oidx_reg), filt_reg};
    assign m_tuser  = osh_reg;
    assign m_tlast  = eor_reg;

endmodule
